@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the matrix-vector transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under reset
`define MVT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock
`define MVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mvt_pkg.sv @@
// ----------------------------------------------------------------------------
// mvt_pkg
// Types, constants and helpers for the 4x4 matrix-vector transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvt_pkg;

    // Arithmetic width of one element; products and sums wrap at this width
    localparam int ELEM_WIDTH      = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int DIM             = 4;
    localparam int NUM_REGS        = 8;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_SEL_WIDTH   = $clog2(NUM_REGS);

    typedef logic [ELEM_WIDTH-1:0] elem_t;
    typedef elem_t [DIM-1:0]        vec_t;
    typedef elem_t [DIM-1:0][DIM-1:0] mat_t;   // [row][col]
    typedef elem_t [DIM-1:0][1:0]   pair_t;    // [row][half]

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] in_x;
        logic signed [FIELD_WIDTH-1:0] in_y;
        logic signed [FIELD_WIDTH-1:0] in_z;
        logic signed [FIELD_WIDTH-1:0] in_w;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] out_x;
        logic signed [FIELD_WIDTH-1:0] out_y;
        logic signed [FIELD_WIDTH-1:0] out_z;
        logic signed [FIELD_WIDTH-1:0] out_w;
    } out_item_t;

    // Sign-extend one element to a full field
    function automatic logic signed [FIELD_WIDTH-1:0] sext_field(elem_t v);
        return FIELD_WIDTH'(signed'(v));
    endfunction

endpackage

@@ hdl/matrix4x4_vector_transform.sv @@
// ----------------------------------------------------------------------------
// matrix4x4_vector_transform
// Streams 4-element signed vectors through a configured 4x4 integer matrix.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_valid/s_ready/s_item carries one vector per item;
//    result channel m_valid/m_ready/m_item returns the four row dot
//    products, wrapped to the element width and sign-extended.
//  - Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
//    eight 64-bit matrix registers (two elements each); cfg_ready is high
//    whenever reset is released and indexes past the last register are
//    dropped. Write only while no item is in flight.
//  - Pipeline: an accepted input passes the input register, multiplier
//    register and two adder-level registers before m_valid rises.
//  - Throughput: one item per cycle while the receiver takes results;
//    sixteen parallel multipliers and the four-stage pipeline set this.
//  - Reset (aresetn low, synchronous) empties the pipeline and clears the
//    matrix to zero; s_ready and cfg_ready stay low while it is held.
//  - When the receiver stalls, the result holds in the output register and
//    upstream stages keep filling until all four are full, then s_ready
//    drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix4x4_vector_transform
    import mvt_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_item
);

    logic [NUM_REGS-1:0][CFG_DATA_WIDTH-1:0] cfg_regs_reg;
    logic  cfg_wr;
    mat_t  matrix;
    logic  prod_valid;
    logic  prod_ready;
    mat_t  prod;

    assign cfg_ready = aresetn;
    assign cfg_wr    = cfg_valid && (cfg_index < CFG_INDEX_WIDTH'(NUM_REGS));

    // Matrix registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_regs_reg <= '0;
        end else if (cfg_wr) begin
            cfg_regs_reg[cfg_index[CFG_SEL_WIDTH-1:0]] <= cfg_data;
        end
    end

    // Unpack: register 2*row + col/2, column odd in the upper slot
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                matrix[r][c] = cfg_regs_reg[r*2 + c/2][(c%2)*FIELD_WIDTH +: ELEM_WIDTH];
            end
        end
    end

    mvt_mul_stage u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .matrix     (matrix),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    mvt_add_tree u_add (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    `MVT_ASSERT_NEXT(ast_cfg_oor, aclk, aresetn, cfg_valid && !cfg_wr, $stable(cfg_regs_reg), "out-of-range write changed the matrix")

endmodule

@@ hdl/mvt_mul_stage.sv @@
// ----------------------------------------------------------------------------
// mvt_mul_stage
// Input register stage and the sixteen element products, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_mul_stage
    import mvt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mat_t     matrix,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     prod_valid,
    input  logic     prod_ready,
    output mat_t     prod
);

    logic  s1_valid_reg;
    vec_t  s1_vec_reg;
    vec_t  s1_vec_next;
    logic  s1_ready;
    logic  s2_valid_reg;
    mat_t  s2_prod_reg;
    mat_t  s2_prod_next;
    logic  s2_ready;

    // Stall chain: a stage loads when empty or when the next one moves
    assign s2_ready = !s2_valid_reg || prod_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    // No item is taken while reset is held
    assign s_ready  = s1_ready && aresetn;

    // Keep only the low element bits of each field
    always_comb begin
        s1_vec_next[0] = ELEM_WIDTH'(s_item.in_x);
        s1_vec_next[1] = ELEM_WIDTH'(s_item.in_y);
        s1_vec_next[2] = ELEM_WIDTH'(s_item.in_z);
        s1_vec_next[3] = ELEM_WIDTH'(s_item.in_w);
    end

    // Low-half products, one multiplier per matrix element
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                s2_prod_next[r][c] = ELEM_WIDTH'(matrix[r][c] * s1_vec_reg[c]);
            end
        end
    end

    // Stage 1: input vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s1_ready && s_valid) begin
            s1_vec_reg <= s1_vec_next;
        end
    end

    // Stage 2: products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_prod_reg <= s2_prod_next;
        end
    end

    assign prod_valid = s2_valid_reg;
    assign prod       = s2_prod_reg;

    `MVT_ASSERT_NEXT(ast_s1_hold, aclk, aresetn, s1_valid_reg && !s1_ready, s1_valid_reg && $stable(s1_vec_reg), "stalled input vector lost")
    `MVT_ASSERT_NEXT(ast_s2_hold, aclk, aresetn, s2_valid_reg && !prod_ready, s2_valid_reg && $stable(s2_prod_reg), "stalled products lost")

endmodule

@@ hdl/mvt_add_tree.sv @@
// ----------------------------------------------------------------------------
// mvt_add_tree
// Two registered adder levels reduce each row's products to one sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_add_tree
    import mvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      prod_valid,
    output logic      prod_ready,
    input  mat_t      prod,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic  s3_valid_reg;
    pair_t s3_pair_reg;
    pair_t s3_pair_next;
    logic  s3_ready;
    logic  s4_valid_reg;
    vec_t  s4_sum_reg;
    vec_t  s4_sum_next;
    logic  s4_ready;

    assign s4_ready   = !s4_valid_reg || m_ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign prod_ready = s3_ready;

    // Level 1: columns 0+1 and 2+3 of each row
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            s3_pair_next[r][0] = prod[r][0] + prod[r][1];
            s3_pair_next[r][1] = prod[r][2] + prod[r][3];
        end
    end

    // Level 2: row sum
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            s4_sum_next[r] = s3_pair_reg[r][0] + s3_pair_reg[r][1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= prod_valid;
        end
        if (s3_ready && prod_valid) begin
            s3_pair_reg <= s3_pair_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= s3_valid_reg;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_sum_reg <= s4_sum_next;
        end
    end

    assign m_valid      = s4_valid_reg;
    assign m_item.out_x = sext_field(s4_sum_reg[0]);
    assign m_item.out_y = sext_field(s4_sum_reg[1]);
    assign m_item.out_z = sext_field(s4_sum_reg[2]);
    assign m_item.out_w = sext_field(s4_sum_reg[3]);

    `MVT_ASSERT_NEXT(ast_s3_hold, aclk, aresetn, s3_valid_reg && !s3_ready, s3_valid_reg && $stable(s3_pair_reg), "stalled partial sums lost")

endmodule

@@ bench/matrix4x4_vector_transform_tb.sv @@
// ----------------------------------------------------------------------------
// matrix4x4_vector_transform_tb
// Self-checking bench for the 4x4 matrix-vector transform. Loads matrices
// through the config channel while the pipeline is idle, streams vectors
// through the input channel with random source gaps and sink stalls, and
// checks every result vector, in order, against a wrapping dot-product model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix4x4_vector_transform_tb;
    import mvt_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 250;
    localparam int MAX_REPORTS  = 10;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]  cfg_word_t;

    // Matrix register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
        ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
    } mat_reg_e;

    // Indexes past the last register; writes there must be dropped
    localparam cfg_index_t FIRST_UNUSED_INDEX = cfg_index_t'(NUM_REGS);
    localparam cfg_index_t LAST_UNUSED_INDEX  = '1;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] NEG1  = -32'sd1;
    localparam logic signed [31:0] ZERO  = 32'sd0;
    localparam logic signed [31:0] ONE   = 32'sd1;

    // One row of the directed plan: a register write or a vector
    typedef struct {
        bit         is_cfg;
        cfg_index_t idx;
        cfg_word_t  data;
        in_item_t   vec;
        bit         typed;
        out_item_t  result;
    } plan_step_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = '0;
    cfg_word_t  cfg_data  = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_item    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_item;

    cfg_word_t  matrix_regs [NUM_REGS];
    out_item_t  pending_results [$];
    plan_step_t plan [$];
    int         mismatch_cnt = 0;
    int         cycle_cnt    = 0;
    int         ready_hold   = 0;
    int         next_gap;
    bit         pace_on      = 1'b1;

    matrix4x4_vector_transform u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Four row dot products, wrapping at the element width
    function automatic out_item_t transform_vec(in_item_t v);
        logic [FIELD_WIDTH-1:0] vin [DIM];
        logic [ELEM_WIDTH-1:0]  acc [DIM];
        logic [ELEM_WIDTH-1:0]  a;
        logic [ELEM_WIDTH-1:0]  b;
        cfg_word_t              word;
        vin[0] = v.in_x;
        vin[1] = v.in_y;
        vin[2] = v.in_z;
        vin[3] = v.in_w;
        for (int r = 0; r < DIM; r++) begin
            acc[r] = '0;
            for (int c = 0; c < DIM; c++) begin
                word   = matrix_regs[r * 2 + c / 2];
                a      = ELEM_WIDTH'(word[32 * (c % 2) +: 32]);
                b      = vin[c][ELEM_WIDTH-1:0];
                acc[r] = acc[r] + ELEM_WIDTH'(a * b);
            end
        end
        return {FIELD_WIDTH'(signed'(acc[0])), FIELD_WIDTH'(signed'(acc[1])),
                FIELD_WIDTH'(signed'(acc[2])), FIELD_WIDTH'(signed'(acc[3]))};
    endfunction

    // Gap length for either side: mostly none, some short, a few long
    function automatic int rand_gap();
        int r;
        if (!pace_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_extreme();
        case ($urandom_range(0, 4))
            0: return S_MAX;
            1: return S_MIN;
            2: return NEG1;
            3: return ZERO;
            default: return ONE;
        endcase
    endfunction

    // Element value: full range, small around zero, or an extreme
    function automatic logic [31:0] rand_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom;
        if (r < 8) return 32'($urandom_range(0, 8)) - 32'd4;
        return rand_extreme();
    endfunction

    function automatic plan_step_t cfg_step(cfg_index_t idx, cfg_word_t data);
        plan_step_t s;
        s        = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic plan_step_t vec_step(in_item_t v);
        plan_step_t s;
        s     = '{default: '0};
        s.vec = v;
        return s;
    endfunction

    // Result known by inspection; only valid at full element width
    function automatic plan_step_t known_step(in_item_t v, out_item_t r);
        plan_step_t s;
        s        = vec_step(v);
        s.typed  = (ELEM_WIDTH == FIELD_WIDTH);
        s.result = r;
        return s;
    endfunction

    // Write one register; caller drops cfg_valid after the last of a batch
    task automatic cfg_write(cfg_index_t idx, cfg_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_REGS) matrix_regs[idx] = data;
    endtask

    // Send one vector and record its expected result on acceptance
    task automatic send_vec(in_item_t v, bit typed, out_item_t r);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= v;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(typed ? r : transform_vec(v));
    endtask

    // Every vector gives one result, so an empty queue means an empty pipe
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Sink stalls
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            next_gap = rand_gap();
            if (next_gap > 0) begin
                ready_hold = next_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("unexpected result x=%0d y=%0d z=%0d w=%0d",
                             m_item.out_x, m_item.out_y, m_item.out_z, m_item.out_w);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_item.out_x !== want.out_x || m_item.out_y !== want.out_y ||
                    m_item.out_z !== want.out_z || m_item.out_w !== want.out_w) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.out_x, want.out_y, want.out_z, want.out_w,
                                 m_item.out_x, m_item.out_y, m_item.out_z,
                                 m_item.out_w);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        bit        cfg_open;
        cfg_word_t slot_lo;
        cfg_word_t slot_hi;
        in_item_t  v;

        for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;

        // Zero matrix after reset; writes past the last register are dropped
        plan.push_back(known_step({S_MAX, S_MAX, S_MAX, S_MAX}, '0));
        plan.push_back(known_step({S_MIN, S_MIN, S_MIN, S_MIN}, '0));
        plan.push_back(cfg_step(FIRST_UNUSED_INDEX, '1));
        plan.push_back(cfg_step(LAST_UNUSED_INDEX, '1));
        plan.push_back(known_step({ONE, ONE, ONE, ONE}, '0));

        // Identity: output equals input, element order preserved
        plan.push_back(cfg_step(ROW0_COLS01, 64'h0000_0000_0000_0001));
        plan.push_back(cfg_step(ROW0_COLS23, 64'h0));
        plan.push_back(cfg_step(ROW1_COLS01, 64'h0000_0001_0000_0000));
        plan.push_back(cfg_step(ROW1_COLS23, 64'h0));
        plan.push_back(cfg_step(ROW2_COLS01, 64'h0));
        plan.push_back(cfg_step(ROW2_COLS23, 64'h0000_0000_0000_0001));
        plan.push_back(cfg_step(ROW3_COLS01, 64'h0));
        plan.push_back(cfg_step(ROW3_COLS23, 64'h0000_0001_0000_0000));
        plan.push_back(known_step({S_MAX, S_MIN, NEG1, ZERO}, {S_MAX, S_MIN, NEG1, ZERO}));
        plan.push_back(known_step({S_MIN, S_MAX, ZERO, NEG1}, {S_MIN, S_MAX, ZERO, NEG1}));
        plan.push_back(known_step({ONE, 32'sd2, 32'sd3, 32'sd4},
                                  {ONE, 32'sd2, 32'sd3, 32'sd4}));

        // All -1: each output is minus the element sum, wrapped
        for (int i = 0; i < NUM_REGS; i++)
            plan.push_back(cfg_step(cfg_index_t'(i), '1));
        plan.push_back(known_step({ONE, 32'sd2, 32'sd3, 32'sd4},
                                  {-32'sd10, -32'sd10, -32'sd10, -32'sd10}));
        plan.push_back(known_step({S_MIN, ZERO, ZERO, ZERO}, {S_MIN, S_MIN, S_MIN, S_MIN}));
        plan.push_back(known_step({S_MAX, S_MAX, S_MAX, S_MAX},
                                  {32'sd4, 32'sd4, 32'sd4, 32'sd4}));

        // Most negative everywhere: products keep only the low bit
        for (int i = 0; i < NUM_REGS; i++)
            plan.push_back(cfg_step(cfg_index_t'(i), 64'h8000_0000_8000_0000));
        plan.push_back(vec_step({ONE, ZERO, ZERO, ZERO}));
        plan.push_back(vec_step({ONE, ONE, ONE, NEG1}));
        plan.push_back(vec_step({S_MIN, S_MAX, NEG1, 32'sd3}));

        // Distinct mixed-sign elements to catch row/column swaps
        plan.push_back(cfg_step(ROW0_COLS01, 64'hFFFF_FFFE_0000_0003));
        plan.push_back(cfg_step(ROW0_COLS23, 64'h0000_0007_FFFF_FFFB));
        plan.push_back(cfg_step(ROW1_COLS01, 64'h0000_000B_FFFF_FFF5));
        plan.push_back(cfg_step(ROW1_COLS23, 64'hFFFF_FFED_0000_0011));
        plan.push_back(cfg_step(ROW2_COLS01, 64'h1234_5678_8765_4321));
        plan.push_back(cfg_step(ROW2_COLS23, 64'h7FFF_FFFF_0000_0002));
        plan.push_back(cfg_step(ROW3_COLS01, 64'h0000_0001_8000_0000));
        plan.push_back(cfg_step(ROW3_COLS23, 64'hDEAD_BEEF_0000_0100));
        plan.push_back(vec_step({ONE, 32'sd2, 32'sd3, 32'sd4}));
        plan.push_back(vec_step({S_MAX, S_MIN, S_MAX, S_MIN}));
        plan.push_back(vec_step({NEG1, 32'sd1000, -32'sd77, 32'sh0F0F_0F0F}));

        // Reset
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan
        cfg_open = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!cfg_open) wait_idle();
                cfg_write(plan[i].idx, plan[i].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_vec(plan[i].vec, plan[i].typed, plan[i].result);
            end
        end

        // Random phases; the last one loads the largest positive element
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            pace_on = (ph % 3 != 2);
            for (int i = 0; i < NUM_REGS; i++) begin
                slot_lo = (ph == RAND_PHASES - 1) ? cfg_word_t'(S_MAX) : rand_elem();
                slot_hi = (ph == RAND_PHASES - 1) ? cfg_word_t'(S_MAX) : rand_elem();
                cfg_write(cfg_index_t'(i), (slot_hi << 32) | slot_lo);
            end
            if ($urandom_range(0, 1))
                cfg_write(cfg_index_t'($urandom_range(NUM_REGS, 2**CFG_INDEX_WIDTH - 1)),
                          {$urandom, $urandom});
            cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                v = {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
                send_vec(v, 1'b0, '0);
            end
        end

        // Drain, then give stray results a chance to show up
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ matrix4x4_vector_transform.f @@
+incdir+hdl
hdl/mvt_pkg.sv
hdl/mvt_mul_stage.sv
hdl/mvt_add_tree.sv
hdl/matrix4x4_vector_transform.sv
bench/matrix4x4_vector_transform_tb.sv
